FILE: rtl/core/max_product_subarray_macros.svh
// Assertion macros shared by the max_product_subarray RTL.
// No dependencies; the assertion bodies compile away when SYNTHESIS is defined.
`ifndef MAX_PRODUCT_SUBARRAY_MACROS_SVH
`define MAX_PRODUCT_SUBARRAY_MACROS_SVH
`ifndef SYNTHESIS
`define MPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MPS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MPS_ASSERT(label, clk, rst, prop, msg)
`define MPS_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

FILE: rtl/core/mps_pkg.sv
// Package for the max_product_subarray block: fixed field widths.
// No dependencies; used by mps_qmul and max_product_subarray.
`default_nettype none
package mps_pkg;
   localparam int VALUE_WIDTH = 16;
   localparam int BEST_WIDTH  = 47;
endpackage
`default_nettype wire

FILE: rtl/core/mps_qmul.sv
// Saturating fixed-point product of a suffix value and one element.
// Depends on mps_pkg for the element width.
`default_nettype none
module mps_qmul #(
   parameter int PRODUCT_WIDTH = 48,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic signed [PRODUCT_WIDTH-1:0]          state,
   input  wire logic signed [mps_pkg::VALUE_WIDTH-1:0]   value,
   output logic signed [PRODUCT_WIDTH-1:0]               product
);
   localparam int VW  = mps_pkg::VALUE_WIDTH;
   localparam int PRW = PRODUCT_WIDTH + VW;
   localparam logic signed [PRW-1:0] BIAS =
      PRW'((64'd1 << FRACTION_BITS) - 64'd1);
   localparam logic signed [PRODUCT_WIDTH-1:0] POS_MAX = {1'b0, {(PRODUCT_WIDTH-1){1'b1}}};
   localparam logic signed [PRODUCT_WIDTH-1:0] NEG_MIN = {1'b1, {(PRODUCT_WIDTH-1){1'b0}}};

   logic signed [PRW-1:0] state_ext;
   logic signed [PRW-1:0] value_ext;
   logic signed [PRW-1:0] full;
   logic signed [PRW-1:0] biased;
   logic signed [PRW-1:0] scaled;
   logic [PRW-PRODUCT_WIDTH:0] upper;

   // Adding the bias to negative products makes the shift truncate toward zero.
   always_comb begin
      state_ext = {{VW{state[PRODUCT_WIDTH-1]}}, state};
      value_ext = {{PRODUCT_WIDTH{value[VW-1]}}, value};
      full      = state_ext * value_ext;
      biased    = full + (full[PRW-1] ? BIAS : '0);
      scaled    = biased >>> FRACTION_BITS;
      upper     = scaled[PRW-1:PRODUCT_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         product = scaled[PRODUCT_WIDTH-1:0];
      end else if (scaled[PRW-1]) begin
         product = NEG_MIN;
      end else begin
         product = POS_MAX;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/max_product_subarray.sv
// An accepted request is held in the input stage, then its response in the output stage.
// Throughput: one transaction per cycle; a stalled response holds both stages.
// The suffix maximum, suffix minimum and best product update together when a request advances.
// Reset is synchronous: it empties both stages and sets all three state
// registers to one in fixed point.
// Depends on mps_pkg, mps_qmul and max_product_subarray_macros.svh.
`default_nettype none
`include "max_product_subarray_macros.svh"
module max_product_subarray #(
   parameter int PRODUCT_WIDTH = 48,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [mps_pkg::VALUE_WIDTH-1:0] req_value,
   input  wire logic                                  req_first,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [mps_pkg::BEST_WIDTH-1:0]             rsp_best_product
);
   localparam int VW = mps_pkg::VALUE_WIDTH;
   localparam logic signed [PRODUCT_WIDTH-1:0] ONE =
      PRODUCT_WIDTH'(64'd1 << FRACTION_BITS);

   logic                          in_valid_ff;
   logic signed [VW-1:0]          in_value_ff;
   logic                          in_first_ff;
   logic                          out_valid_ff;
   logic [mps_pkg::BEST_WIDTH-1:0] out_best_ff;
   logic [mps_pkg::BEST_WIDTH-1:0] out_best_in;

   logic signed [PRODUCT_WIDTH-1:0] best_run_ff,   best_run_in;
   logic signed [PRODUCT_WIDTH-1:0] max_suffix_ff, max_suffix_in;
   logic signed [PRODUCT_WIDTH-1:0] min_suffix_ff, min_suffix_in;

   logic signed [PRODUCT_WIDTH-1:0] value_ext;
   logic signed [PRODUCT_WIDTH-1:0] p_max;
   logic signed [PRODUCT_WIDTH-1:0] p_min;
   logic signed [PRODUCT_WIDTH-1:0] hi_base, lo_base, hi_prod, lo_prod;
   logic                          advance;
   logic                          req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_best_product = out_best_ff;

   mps_qmul #(
      .PRODUCT_WIDTH(PRODUCT_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_qmul_max (
      .state  (max_suffix_ff),
      .value  (in_value_ff),
      .product(p_max)
   );

   mps_qmul #(
      .PRODUCT_WIDTH(PRODUCT_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_qmul_min (
      .state  (min_suffix_ff),
      .value  (in_value_ff),
      .product(p_min)
   );

   always_comb begin
      value_ext = {{(PRODUCT_WIDTH-VW){in_value_ff[VW-1]}}, in_value_ff};
      hi_base   = (value_ext > ONE) ? value_ext : ONE;
      lo_base   = (value_ext < ONE) ? value_ext : ONE;
      hi_prod   = (p_max > p_min) ? p_max : p_min;
      lo_prod   = (p_max < p_min) ? p_max : p_min;
      if (in_first_ff) begin
         max_suffix_in = hi_base;
         min_suffix_in = lo_base;
         best_run_in   = hi_base;
      end else begin
         max_suffix_in = (hi_prod > hi_base) ? hi_prod : hi_base;
         min_suffix_in = (lo_prod < lo_base) ? lo_prod : lo_base;
         best_run_in   = (max_suffix_in > best_run_ff) ? max_suffix_in : best_run_ff;
      end
      out_best_in = mps_pkg::BEST_WIDTH'($unsigned(best_run_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         best_run_ff   <= ONE;
         max_suffix_ff <= ONE;
         min_suffix_ff <= ONE;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff  <= 1'b1;
            best_run_ff   <= best_run_in;
            max_suffix_ff <= max_suffix_in;
            min_suffix_ff <= min_suffix_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_value_ff <= req_value;
         in_first_ff <= req_first;
      end
      if (advance) begin
         out_best_ff <= out_best_in;
      end
   end

   `MPS_ASSERT(a_best_at_least_one, clock, reset, best_run_ff >= ONE, "Best product fell below one.")
   `MPS_ASSERT(a_suffix_order, clock, reset, max_suffix_ff >= min_suffix_ff, "Suffix bounds crossed.")
   `MPS_ASSERT(a_best_covers_suffix, clock, reset, best_run_ff >= max_suffix_ff, "Best product below suffix maximum.")
   `MPS_ASSERT_NEXT(a_state_holds_on_stall, clock, reset, out_valid_ff && rsp_stall, $stable(best_run_ff) && $stable(max_suffix_ff), "State changed while the response was stalled.")
endmodule
`default_nettype wire

FILE: tb/max_product_subarray_checker.sv
// Checker for max_product_subarray: watches both channels, predicts the running best product
// and compares every response transaction against it.
// Depends on mps_pkg for the field widths.
`timescale 1ns / 100ps
module max_product_subarray_checker #(
   parameter int PRODUCT_WIDTH = 48,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic signed [mps_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic                                    req_first,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic [mps_pkg::BEST_WIDTH-1:0]          rsp_best_product,
   output int                                      mismatch_count,
   output int                                      outstanding
);

   localparam longint ONE_Q = longint'(1) << FRACTION_BITS;
   localparam longint SAT_HIGH = (longint'(1) << (PRODUCT_WIDTH - 1)) - 1;
   localparam longint SAT_LOW = -(longint'(1) << (PRODUCT_WIDTH - 1));

   longint best_run = ONE_Q;
   longint max_suffix = ONE_Q;
   longint min_suffix = ONE_Q;
   logic [mps_pkg::BEST_WIDTH-1:0] best_expected[$];

   initial mismatch_count = 0;
   initial outstanding = 0;

   // The magnitude is truncated toward zero before saturation.
   function automatic longint scaled_product(input longint run, input longint element);
      longint full;
      longint mag;
      full = run * element;
      mag = (full < 0) ? -full : full;
      mag = mag >> FRACTION_BITS;
      if (full < 0)
         return (-mag < SAT_LOW) ? SAT_LOW : -mag;
      return (mag > SAT_HIGH) ? SAT_HIGH : mag;
   endfunction

   function automatic longint larger(input longint a, input longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic longint smaller(input longint a, input longint b);
      return (a < b) ? a : b;
   endfunction

   always @(posedge clock) begin : track
      longint element;
      longint up;
      longint down;
      longint new_max;
      longint new_min;
      logic [mps_pkg::BEST_WIDTH-1:0] expected;
      if (reset) begin
         best_run = ONE_Q;
         max_suffix = ONE_Q;
         min_suffix = ONE_Q;
         best_expected.delete();
         outstanding <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            element = longint'(req_value);
            if (req_first) begin
               max_suffix = larger(ONE_Q, element);
               min_suffix = smaller(ONE_Q, element);
               best_run = max_suffix;
            end else begin
               up = scaled_product(max_suffix, element);
               down = scaled_product(min_suffix, element);
               new_max = larger(larger(ONE_Q, element), larger(up, down));
               new_min = smaller(smaller(ONE_Q, element), smaller(up, down));
               max_suffix = new_max;
               min_suffix = new_min;
               best_run = larger(best_run, max_suffix);
            end
            best_expected.push_back(best_run[mps_pkg::BEST_WIDTH-1:0]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (best_expected.size() == 0) begin
               $error("best_product: expected nothing, actual %0d", rsp_best_product);
               mismatch_count <= mismatch_count + 1;
            end else begin
               expected = best_expected.pop_front();
               if (rsp_best_product !== expected) begin
                  $error("best_product: expected %0d, actual %0d", expected, rsp_best_product);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         outstanding <= best_expected.size();
      end
   end

endmodule

FILE: tb/tb.sv
// Top of the max_product_subarray testbench: clock, reset, directed and random stimulus.
// Depends on max_product_subarray, its package and max_product_subarray_checker.
`timescale 1ns / 100ps
module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic signed [mps_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic req_first = 1'b0;
   logic rsp_stall = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic [mps_pkg::BEST_WIDTH-1:0] rsp_best_product;
   int mismatch_count;
   int outstanding;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int cycle_count = 0;

   always #4 clock = ~clock;

   max_product_subarray i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_first        (req_first),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_best_product (rsp_best_product)
   );

   max_product_subarray_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_first        (req_first),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_best_product (rsp_best_product),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic send_element(input logic signed [mps_pkg::VALUE_WIDTH-1:0] value,
                               input logic first);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_first <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic signed [mps_pkg::VALUE_WIDTH-1:0] pick_element();
      int v;
      case ($urandom_range(9))
         0, 1, 2: v = $urandom_range(16'hFFFF);
         3, 4:    v = int'($urandom_range(1023)) - 512;
         5:       v = (256 + int'($urandom_range(256))) * ($urandom_range(1) ? 1 : -1);
         6:       v = 0;
         7:       v = $urandom_range(1) ? 256 : -256;
         8: begin
            case ($urandom_range(3))
               0:       v = 32767;
               1:       v = -32768;
               2:       v = -1;
               default: v = 1;
            endcase
         end
         default: v = int'($urandom_range(511)) - 255;
      endcase
      return v[mps_pkg::VALUE_WIDTH-1:0];
   endfunction

   // Mostly well-formed sequences; some start without a first flag or restart midway.
   task automatic run_sequences(input int items);
      int sent;
      int length;
      logic broken;
      sent = 0;
      while (sent < items) begin
         length = $urandom_range(1, 24);
         broken = ($urandom_range(9) == 0);
         for (int k = 0; k < length && sent < items; k++) begin
            send_element(pick_element(), (k == 0) ? !broken : ($urandom_range(49) == 0));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Continue straight from the reset state, then the extremes and a zero element.
      send_element(16'sd512, 1'b0);
      send_element(-16'sd32768, 1'b0);
      send_element(16'sd32767, 1'b0);
      send_element(16'sd0, 1'b0);
      send_element(-16'sd1, 1'b1);
      send_element(16'sd1, 1'b0);
      send_element(16'sd256, 1'b0);
      send_element(-16'sd256, 1'b0);
      // Drive the suffixes into positive and then negative saturation.
      send_element(16'sd32767, 1'b1);
      repeat (6) send_element(16'sd32767, 1'b0);
      repeat (2) send_element(-16'sd32768, 1'b0);
      send_element(16'sd0, 1'b0);
      send_element(-16'sd32768, 1'b0);
      wait_until_drained();

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      run_sequences(PHASE_ITEMS);
      wait_until_drained();

      sender_idle_pct = 46;
      receiver_stall_pct = 0;
      run_sequences(PHASE_ITEMS);
      wait_until_drained();

      sender_idle_pct = 0;
      receiver_stall_pct = 46;
      run_sequences(PHASE_ITEMS);
      wait_until_drained();

      sender_idle_pct = 38;
      receiver_stall_pct = 38;
      run_sequences(PHASE_ITEMS);
      wait_until_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: max_product_subarray.f
+incdir+rtl/core
rtl/core/mps_pkg.sv
rtl/core/mps_qmul.sv
rtl/core/max_product_subarray.sv
tb/max_product_subarray_checker.sv
tb/tb.sv
